// ===== design/spci_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_pkg
// Shared types and constants for the segment/plane classify-intersect block.
// ----------------------------------------------------------------------------
package spci_pkg;

    localparam int COORD_W   = 16;
    localparam int PLANE_W   = 32;
    localparam int FRAC_W    = 12;
    localparam int DND_W     = PLANE_W + FRAC_W;  // |num| << 12
    localparam int DIV_STEPS = DND_W;             // one quotient bit per cell

    localparam logic [1:0] REG_PLANE_A      = 2'd0;
    localparam logic [1:0] REG_PLANE_B      = 2'd1;
    localparam logic [1:0] REG_PLANE_C      = 2'd2;
    localparam logic [1:0] REG_PLANE_OFFSET = 2'd3;

    localparam logic [1:0] SIDE_ON    = 2'd0;
    localparam logic [1:0] SIDE_FRONT = 2'd1;
    localparam logic [1:0] SIDE_BACK  = 2'd2;

    typedef logic [COORD_W-1:0] coord_t;

    // Everything that travels along the divider cell chain.
    typedef struct packed {
        logic [1:0]         start_side;
        logic [1:0]         end_side;
        logic               hit_ok;
        logic               neg;
        logic [PLANE_W-1:0] dvs;
        logic [DND_W-1:0]   dnd;
        logic [PLANE_W-1:0] rem;
        logic [PLANE_W-1:0] quo;
        coord_t [2:0]       p0;
        coord_t [2:0]       dir;
    } div_item_t;

    function automatic logic [1:0] side_of(input logic [PLANE_W-1:0] s);
        logic [1:0] r;
        if (s == '0) begin
            r = SIDE_ON;
        end else if (s[PLANE_W-1]) begin
            r = SIDE_BACK;
        end else begin
            r = SIDE_FRONT;
        end
        return r;
    endfunction

endpackage

// ===== design/segment_plane_classify_intersect.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_plane_classify_intersect
// Classifies both segment endpoints against a configured plane and computes
// the point where the segment's line crosses that plane.
// ----------------------------------------------------------------------------
// Between an accepted request and its result on m_tvalid lie 3 front-end
//   stages, 44 divider cells, 2 back-end stages and the output register.
// Throughput: one request per cycle; the 44-cell divider chain sets the depth.
// The whole pipeline advances together and holds while a result is stalled.
// Reset (synchronous, aresetn low) clears all valid flags and the plane
//   registers to zero; payload registers are not reset.
// ----------------------------------------------------------------------------
module segment_plane_classify_intersect (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_x[15:0], start_y[31:16], start_z[47:32],
    // end_x[63:48], end_y[79:64], end_z[95:80]
    input  logic [95:0] s_tdata,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // start_side[1:0], end_side[3:2], hit_x[19:4], hit_y[35:20],
    // hit_z[51:36], zero fill [55:52]
    output logic [55:0] m_tdata,
    // hit_valid[0]
    output logic [0:0]  m_tuser
);
    import spci_pkg::*;

    // Plane registers.
    logic [PLANE_W-1:0] plane_a_reg, plane_b_reg, plane_c_reg, plane_d_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_a_reg <= '0;
            plane_b_reg <= '0;
            plane_c_reg <= '0;
            plane_d_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_PLANE_A:      plane_a_reg <= cfg_wdata;
                REG_PLANE_B:      plane_b_reg <= cfg_wdata;
                REG_PLANE_C:      plane_c_reg <= cfg_wdata;
                REG_PLANE_OFFSET: plane_d_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register can take data.
    logic        out_valid_reg;
    logic        en;
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    coord_t [2:0] in_p0, in_p1;
    assign in_p0[0] = s_tdata[15:0];
    assign in_p0[1] = s_tdata[31:16];
    assign in_p0[2] = s_tdata[47:32];
    assign in_p1[0] = s_tdata[63:48];
    assign in_p1[1] = s_tdata[79:64];
    assign in_p1[2] = s_tdata[95:80];

    // Stage 1: the six plane products, each shifted right by 12 and wrapped.
    logic signed [47:0] pr0 [3];
    logic signed [47:0] pr1 [3];
    logic [PLANE_W-1:0] coef [3];
    assign coef[0] = plane_a_reg;
    assign coef[1] = plane_b_reg;
    assign coef[2] = plane_c_reg;

    logic               s1_valid_reg;
    logic [PLANE_W-1:0] s1_m0_reg [3];
    logic [PLANE_W-1:0] s1_m1_reg [3];
    coord_t [2:0]       s1_p0_reg, s1_p1_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pr0[k] = $signed(coef[k]) * $signed(in_p0[k]);
            pr1[k] = $signed(coef[k]) * $signed(in_p1[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s1_m0_reg[k] <= pr0[k][43:12];
                s1_m1_reg[k] <= pr1[k][43:12];
            end
            s1_p0_reg <= in_p0;
            s1_p1_reg <= in_p1;
        end
    end

    // Stage 2: the two dot products, and the direction vector.
    logic               s2_valid_reg;
    logic [PLANE_W-1:0] s2_d0_reg, s2_d1_reg;
    coord_t [2:0]       s2_p0_reg, s2_dir_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_d0_reg <= s1_m0_reg[0] + s1_m0_reg[1] + s1_m0_reg[2];
            s2_d1_reg <= s1_m1_reg[0] + s1_m1_reg[1] + s1_m1_reg[2];
            s2_p0_reg <= s1_p0_reg;
            for (int k = 0; k < 3; k++) begin
                s2_dir_reg[k] <= s1_p1_reg[k] - s1_p0_reg[k];
            end
        end
    end

    // Stage 3: numerator, denominator, sides and the divider's operands.
    logic [PLANE_W-1:0] num, den, end_s, abs_num, abs_den;
    logic               s3_valid_reg;
    div_item_t          s3_item_reg;
    div_item_t          s3_item_next;

    always_comb begin
        num     = s2_d0_reg + plane_d_reg;
        den     = s2_d0_reg - s2_d1_reg;
        end_s   = s2_d1_reg + plane_d_reg;
        abs_num = num[PLANE_W-1] ? (~num + 1'b1) : num;
        abs_den = den[PLANE_W-1] ? (~den + 1'b1) : den;
        s3_item_next.start_side = side_of(num);
        s3_item_next.end_side   = side_of(end_s);
        s3_item_next.hit_ok     = (den != '0);
        s3_item_next.neg        = num[PLANE_W-1] ^ den[PLANE_W-1];
        s3_item_next.dvs        = abs_den;
        s3_item_next.dnd        = {abs_num, {FRAC_W{1'b0}}};
        s3_item_next.rem        = '0;
        s3_item_next.quo        = '0;
        s3_item_next.p0         = s2_p0_reg;
        s3_item_next.dir        = s2_dir_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_item_reg <= s3_item_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_tvalid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // Divider: a chain of identical cells, one quotient bit per cell. Only
    // the low 32 quotient bits are kept, which is the wrapped parameter t.
    logic      chain_valid [DIV_STEPS+1];
    div_item_t chain_item  [DIV_STEPS+1];
    assign chain_valid[0] = s3_valid_reg;
    assign chain_item[0]  = s3_item_reg;

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_cell
        spci_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_item   (chain_item[g]),
            .out_valid (chain_valid[g+1]),
            .out_item  (chain_item[g+1])
        );
    end

    // Back end stage A: apply the quotient's sign.
    div_item_t          da_item;
    logic               ta_valid_reg;
    logic [PLANE_W-1:0] ta_t_reg;
    logic [3:0]         ta_side_reg;
    logic               ta_ok_reg;
    coord_t [2:0]       ta_p0_reg, ta_dir_reg;
    assign da_item = chain_item[DIV_STEPS];

    always_ff @(posedge aclk) begin
        if (en) begin
            ta_t_reg    <= da_item.neg ? (~da_item.quo + 1'b1) : da_item.quo;
            ta_side_reg <= {da_item.end_side, da_item.start_side};
            ta_ok_reg   <= da_item.hit_ok;
            ta_p0_reg   <= da_item.p0;
            ta_dir_reg  <= da_item.dir;
        end
    end

    // Back end stage B: direction times t; only bits 27:12 reach the result.
    logic signed [47:0] hp [3];
    logic               tb_valid_reg;
    coord_t [2:0]       tb_off_reg, tb_p0_reg;
    logic [3:0]         tb_side_reg;
    logic               tb_ok_reg;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hp[k] = $signed(ta_dir_reg[k]) * $signed(ta_t_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                tb_off_reg[k] <= hp[k][27:12];
            end
            tb_p0_reg   <= ta_p0_reg;
            tb_side_reg <= ta_side_reg;
            tb_ok_reg   <= ta_ok_reg;
        end
    end

    // Output register: final add, zeroed for a parallel segment.
    logic [51:0] out_data_reg;
    logic        out_ok_reg;
    coord_t [2:0] hit;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            hit[k] = tb_ok_reg ? (tb_p0_reg[k] + tb_off_reg[k]) : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_data_reg <= {hit[2], hit[1], hit[0], tb_side_reg};
            out_ok_reg   <= tb_ok_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ta_valid_reg  <= 1'b0;
            tb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            ta_valid_reg  <= chain_valid[DIV_STEPS];
            tb_valid_reg  <= ta_valid_reg;
            out_valid_reg <= tb_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_data_reg};
    assign m_tuser  = out_ok_reg;

endmodule

// ===== design/spci_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_div_cell
// One restoring-division step: shifts in one dividend bit, yields one
// quotient bit and hands the item to the next cell.
// ----------------------------------------------------------------------------
module spci_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  spci_pkg::div_item_t in_item,
    output logic                out_valid,
    output spci_pkg::div_item_t out_item
);
    import spci_pkg::*;

    logic                valid_reg;
    div_item_t           item_reg;
    div_item_t           item_next;
    logic [PLANE_W:0]    shifted;
    logic [PLANE_W:0]    diff;
    logic                ge;

    always_comb begin
        shifted   = {in_item.rem, in_item.dnd[DND_W-1]};
        diff      = shifted - {1'b0, in_item.dvs};
        ge        = (shifted >= {1'b0, in_item.dvs});
        item_next = in_item;
        item_next.rem = ge ? diff[PLANE_W-1:0] : shifted[PLANE_W-1:0];
        item_next.dnd = {in_item.dnd[DND_W-2:0], 1'b0};
        item_next.quo = {in_item.quo[PLANE_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== design/spci_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spci_checker
// Port-level checks for the segment/plane classify-intersect block.
// ----------------------------------------------------------------------------
module spci_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [55:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import spci_pkg::*;

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A parallel segment reports a zero hit point.
    a_parallel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[51:4] == '0)
        else $error("hit point not zero for parallel segment");

    // Side codes are never the unused code.
    a_side_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3 && m_tdata[3:2] != 2'd3)
        else $error("bad side code");

    // No result right after reset.
    a_reset_empty: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind segment_plane_classify_intersect spci_checker u_spci_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the segment/plane classify-intersect block. Plane
// registers are written between phases, segments stream in with random gaps,
// and every result is compared against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_top;

    import spci_pkg::*;

    // One segment request and the result it is expected to produce.
    typedef struct {
        logic [15:0] sx, sy, sz, ex, ey, ez;
    } segment_t;

    typedef struct packed {
        logic [1:0]  start_side;
        logic [1:0]  end_side;
        logic [15:0] hx, hy, hz;
        logic        hit_valid;
    } crossing_t;

    // Directed row: a segment, and a typed-in result where one is obvious.
    typedef struct {
        segment_t  seg;
        bit        typed;
        crossing_t want;
    } seg_row_t;

    localparam int LATENCY = 50;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [0:0]  m_tuser;

    // Local copy of the plane held by the block.
    logic signed [31:0] pa, pb, pc, pd;

    crossing_t expected_q[$];
    int        mismatches = 0;
    bit        stall_free = 1'b0;
    int        stall_left = 0;

    always #5 aclk = ~aclk;

    segment_plane_classify_intersect u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Fixed-point multiply: full product, arithmetic shift by 12, 32-bit wrap.
    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return 32'(p >>> 12);
    endfunction

    function automatic logic [1:0] side_code(input logic signed [31:0] s);
        if (s == 0) return SIDE_ON;
        return (s < 0) ? SIDE_BACK : SIDE_FRONT;
    endfunction

    // Classifies both endpoints and locates the crossing with the plane.
    function automatic crossing_t predict_crossing(input segment_t g);
        logic signed [31:0] p0[3], p1[3];
        logic signed [31:0] d0, d1, num, den, t, h;
        logic signed [63:0] q;
        logic signed [15:0] dir;
        crossing_t r;
        p0[0] = 32'(signed'(g.sx)); p0[1] = 32'(signed'(g.sy));
        p0[2] = 32'(signed'(g.sz));
        p1[0] = 32'(signed'(g.ex)); p1[1] = 32'(signed'(g.ey));
        p1[2] = 32'(signed'(g.ez));
        d0 = fx_mul(pa, p0[0]) + fx_mul(pb, p0[1]) + fx_mul(pc, p0[2]);
        d1 = fx_mul(pa, p1[0]) + fx_mul(pb, p1[1]) + fx_mul(pc, p1[2]);
        num = d0 + pd;
        den = d0 - d1;
        r.start_side = side_code(num);
        r.end_side   = side_code(d1 + pd);
        r.hx = '0; r.hy = '0; r.hz = '0;
        r.hit_valid = 1'b0;
        if (den != 0) begin
            // Truncating division toward zero, quotient wrapped to 32 bits.
            q = (64'(num) * 64'sd4096) / 64'(den);
            t = 32'(q);
            for (int k = 0; k < 3; k++) begin
                dir = 16'(p1[k] - p0[k]);
                h = p0[k] + fx_mul(32'(dir), t);
                if (k == 0) r.hx = h[15:0];
                else if (k == 1) r.hy = h[15:0];
                else r.hz = h[15:0];
            end
            r.hit_valid = 1'b1;
        end
        return r;
    endfunction

    // Writes one plane register in both the block and the local copy.
    task automatic write_plane(input logic [1:0] idx, input logic [31:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
        case (idx)
            REG_PLANE_A: pa = v;
            REG_PLANE_B: pb = v;
            REG_PLANE_C: pc = v;
            default:     pd = v;
        endcase
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_plane(input logic [31:0] a, b, c, d);
        write_plane(REG_PLANE_A, a);
        write_plane(REG_PLANE_B, b);
        write_plane(REG_PLANE_C, c);
        write_plane(REG_PLANE_OFFSET, d);
    endtask

    // Waits for every outstanding result, then lets the pipe settle.
    task automatic drain_pipe;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    // Presents one request, with a random gap first unless idling is off.
    // The typed-in result, when given, is cross-checked against the predictor.
    task automatic send_segment(input segment_t g, input bit typed, input crossing_t want);
        crossing_t r;
        if (!stall_free && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        r = predict_crossing(g);
        if (typed && r != want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("typed result %h disagrees with prediction %h for %h",
                         want, r, {g.ez, g.ey, g.ex, g.sz, g.sy, g.sx});
        end
        expected_q.insert(expected_q.size(), typed ? want : r);
        s_tvalid <= 1'b1;
        s_tdata  <= {g.ez, g.ey, g.ex, g.sz, g.sy, g.sx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Random coordinate, biased toward extremes and small values.
    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 8192) - 4096);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_plane();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'($urandom_range(0, 16384) - 8192);
            default: return $urandom;
        endcase
    endfunction

    // Result side: random backpressure in bursts, none near the end.
    always @(posedge aclk) begin
        if (!aresetn || stall_free) begin
            stall_left <= 0;
            m_tready   <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 13);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        crossing_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                w = expected_q.pop_front();
                if (m_tdata[1:0] !== w.start_side || m_tdata[3:2] !== w.end_side ||
                    m_tdata[19:4] !== w.hx || m_tdata[35:20] !== w.hy ||
                    m_tdata[51:36] !== w.hz || m_tdata[55:52] !== 4'd0 ||
                    m_tuser[0] !== w.hit_valid) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp side %0d/%0d hit %h %h %h v%0b, got %h u%0b",
                                 w.start_side, w.end_side, w.hx, w.hy, w.hz,
                                 w.hit_valid, m_tdata, m_tuser);
                end
            end
        end
    end

    seg_row_t directed[$];

    function automatic seg_row_t row(input logic [15:0] sx, sy, sz, ex, ey, ez,
                                     input bit typed, input crossing_t w);
        seg_row_t r;
        r.seg = '{sx, sy, sz, ex, ey, ez};
        r.typed = typed;
        r.want = w;
        return r;
    endfunction

    // Appends one row to the directed table.
    task automatic add_row(input seg_row_t r);
        directed.insert(directed.size(), r);
    endtask

    initial begin
        crossing_t none, flat;
        segment_t g;
        pa = 0; pb = 0; pc = 0; pd = 0;
        none = '{SIDE_ON, SIDE_ON, 16'h0, 16'h0, 16'h0, 1'b0};
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // After reset the plane is all zero: every point is on it and the
        // denominator is zero, so nothing ever crosses.
        add_row(row(16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 1, none));
        add_row(row(16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff,
                    16'h7fff, 1, none));
        foreach (directed[i]) send_segment(directed[i].seg, directed[i].typed,
                                           directed[i].want);
        s_tvalid <= 1'b0;
        drain_pipe();

        // Plane z = 0 (C = 1.0): a segment from z=-1 to z=+1 crosses at origin.
        load_plane(32'h0, 32'h0, 32'h1000, 32'h0);
        directed.delete();
        flat = '{SIDE_BACK, SIDE_FRONT, 16'h0, 16'h0, 16'h0, 1'b1};
        add_row(row(16'h0, 16'h0, 16'hf000, 16'h0, 16'h0, 16'h1000, 1, flat));
        // Parallel to the plane, above it: sides reported, no hit.
        flat = '{SIDE_FRONT, SIDE_FRONT, 16'h0, 16'h0, 16'h0, 1'b0};
        add_row(row(16'h0, 16'h0, 16'h1000, 16'h2000, 16'h3000, 16'h1000, 1, flat));
        // Start lying on the plane.
        add_row(row(16'h1234, 16'h0, 16'h0, 16'h0, 16'h0, 16'h7fff, 0, none));
        // Extremes of every field, both orders.
        add_row(row(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
                    16'h7fff, 0, none));
        add_row(row(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff,
                    16'h8000, 0, none));
        add_row(row(16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001,
                    16'h0001, 0, none));
        foreach (directed[i]) send_segment(directed[i].seg, directed[i].typed,
                                           directed[i].want);
        s_tvalid <= 1'b0;
        drain_pipe();

        // Extreme plane: direction wrap and quotient overflow.
        load_plane(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff);
        directed.delete();
        add_row(row(16'h7fff, 16'h8000, 16'h0, 16'h8000, 16'h7fff, 16'h1, 0, none));
        add_row(row(16'h1, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 0, none));
        add_row(row(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                    16'h8000, 0, none));
        foreach (directed[i]) send_segment(directed[i].seg, directed[i].typed,
                                           directed[i].want);
        s_tvalid <= 1'b0;
        drain_pipe();

        // Random phases, each with a fresh plane.
        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 11) stall_free = 1'b1;
            if (ph == 0) load_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            else load_plane(rand_plane(), rand_plane(), rand_plane(), rand_plane());
            for (int n = 0; n < 155; n++) begin
                g = '{rand_coord(), rand_coord(), rand_coord(),
                      rand_coord(), rand_coord(), rand_coord()};
                // Some segments have zero length (end equals start) on purpose.
                if ($urandom_range(0, 9) == 0) g = '{g.sx, g.sy, g.sz, g.sx, g.sy, g.sz};
                send_segment(g, 1'b0, none);
            end
            s_tvalid <= 1'b0;
            drain_pipe();
        end

        if (mismatches == 0 && expected_q.size() == 0)
            $display("** segment_plane_classify_intersect: PASSED **");
        else
            $display("** segment_plane_classify_intersect: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #20ms;
        $display("** segment_plane_classify_intersect: FAILED **");
        $finish;
    end

endmodule
